// File: rtl/quadratic_bisection_root_finder_macros.svh
// Assertion helpers shared by the root finder
`ifndef QUADRATIC_BISECTION_ROOT_FINDER_MACROS_SVH
`define QUADRATIC_BISECTION_ROOT_FINDER_MACROS_SVH

// Same-cycle implication, masked during reset
`define QBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qbr assertion failed");

// Next-cycle implication, masked during reset
`define QBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qbr assertion failed");

`endif

// File: rtl/qbr_pkg.sv
package qbr_pkg;

    localparam int WORD_BITS      = 32;
    localparam int TOL_BITS       = 31;
    localparam int STEP_BITS      = 31;
    localparam int ITER_BITS      = 6;
    localparam int STATUS_BITS    = 2;
    localparam int ADDR_BITS      = 5;
    localparam int CFG_INDEX_BITS = 3;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_BITS-1:0]        addr_t;

    // Request kinds
    localparam logic REQ_BISECT = 1'b0;
    localparam logic REQ_SCAN   = 1'b1;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_EXACT = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_CONV  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NONE  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_QUAD  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_LIN   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_CONST = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCAN_STEP  = 3'd4;

    localparam word_t                COEF_QUAD_RESET  = 32'sd4194304;
    localparam word_t                COEF_LIN_RESET   = 32'sd3145728;
    localparam word_t                COEF_CONST_RESET = -32'sd3145728;
    localparam logic [TOL_BITS-1:0]  TOLERANCE_RESET  = 31'd1;
    localparam logic [STEP_BITS-1:0] SCAN_STEP_RESET  = 31'd104858;

    typedef struct packed {
        logic  req_type;
        word_t lower_bound;
        word_t upper_bound;
    } req_t;

    typedef struct packed {
        word_t                  root;
        logic [STATUS_BITS-1:0] status;
        logic [ITER_BITS-1:0]   iterations;
    } res_t;

    typedef struct packed {
        word_t                 quad;
        word_t                 lin;
        word_t                 cnst;
        logic [TOL_BITS-1:0]   tol;
        logic [STEP_BITS-1:0]  scan_step;
    } coef_t;

    typedef struct packed {
        logic scan_req;
        logic sa_zero;
        logic f_zero;
        logic same;
        logic done;
        logic scan_end;
        logic bracket;
    } flags_t;

    typedef enum logic [1:0] {BR_NEXT, BR_JUMP, BR_CALL, BR_RET} br_t;

    typedef enum logic [3:0] {
        C_ALWAYS, C_NO_START, C_SCAN_REQ, C_SA_ZERO, C_F_ZERO,
        C_SAME, C_DONE, C_SCAN_END, C_BRACKET
    } cond_t;

    typedef enum logic [2:0] {X_NONE, X_LO, X_HI, X_MID, X_SX} xsel_t;
    typedef enum logic [2:0] {M_NONE, M_QX, M_LX, M_TLO, M_THI} mop_t;
    typedef enum logic [2:0] {A_NONE, A_CONST, A_ADD_FRAC, A_ADD_LOW, A_ADD_HIGH} aop_t;

    typedef enum logic [2:0] {
        L_NONE, L_SAVE_A, L_INIT_LOOP, L_LD_WIDTH,
        L_UPDATE, L_CNT_CLR, L_LOAD_WIN, L_SCAN_ADV
    } lop_t;

    typedef enum logic [1:0] {R_ZERO, R_LO, R_HI, R_MID} rsel_t;

    typedef struct packed {
        br_t                    br;
        cond_t                  cond;
        addr_t                  target;
        xsel_t                  xsel;
        mop_t                   mop;
        aop_t                   aop;
        logic                   save_t;
        logic                   sign_ld;
        lop_t                   lop;
        logic                   emit;
        rsel_t                  rsel;
        logic [STATUS_BITS-1:0] status;
    } ctrl_t;

    // Program addresses
    localparam addr_t U_IDLE       = 5'd0;
    localparam addr_t U_DISPATCH   = 5'd1;
    localparam addr_t U_BIS        = 5'd2;
    localparam addr_t U_BIS_HI     = 5'd3;
    localparam addr_t U_BIS_CHK_A  = 5'd4;
    localparam addr_t U_BIS_CHK_B  = 5'd5;
    localparam addr_t U_BIS_CHK_S  = 5'd6;
    localparam addr_t U_BIS_INIT   = 5'd7;
    localparam addr_t U_LOOP       = 5'd8;
    localparam addr_t U_LOOP_TEST  = 5'd9;
    localparam addr_t U_LOOP_EVAL  = 5'd10;
    localparam addr_t U_LOOP_ZERO  = 5'd11;
    localparam addr_t U_LOOP_UPD   = 5'd12;
    localparam addr_t U_SCAN       = 5'd13;
    localparam addr_t U_SCAN_TOP   = 5'd14;
    localparam addr_t U_SCAN_LO    = 5'd15;
    localparam addr_t U_SCAN_HI    = 5'd16;
    localparam addr_t U_SCAN_CHK   = 5'd17;
    localparam addr_t U_SCAN_ADV   = 5'd18;
    localparam addr_t U_EMIT_LO    = 5'd19;
    localparam addr_t U_EMIT_HI    = 5'd20;
    localparam addr_t U_EMIT_NONE  = 5'd21;
    localparam addr_t U_EMIT_EXACT = 5'd22;
    localparam addr_t U_EMIT_CONV  = 5'd23;
    localparam addr_t U_EVAL       = 5'd24;
    localparam addr_t U_EVAL_1     = 5'd25;
    localparam addr_t U_EVAL_2     = 5'd26;
    localparam addr_t U_EVAL_3     = 5'd27;
    localparam addr_t U_EVAL_4     = 5'd28;
    localparam addr_t U_EVAL_5     = 5'd29;

    // Microcode store: one control word per program address
    function automatic ctrl_t ucode(input addr_t pc);
        ctrl_t c;
        c = '0;
        unique case (pc)
            U_IDLE:       begin c.br = BR_JUMP; c.cond = C_NO_START; c.target = U_IDLE; end
            U_DISPATCH:   begin c.br = BR_JUMP; c.cond = C_SCAN_REQ; c.target = U_SCAN; end
            U_BIS:        begin c.br = BR_CALL; c.target = U_EVAL; c.xsel = X_LO; end
            U_BIS_HI:
            begin
                c.br = BR_CALL; c.target = U_EVAL; c.xsel = X_HI; c.lop = L_SAVE_A;
            end
            U_BIS_CHK_A:  begin c.br = BR_JUMP; c.cond = C_SA_ZERO; c.target = U_EMIT_LO; end
            U_BIS_CHK_B:  begin c.br = BR_JUMP; c.cond = C_F_ZERO; c.target = U_EMIT_HI; end
            U_BIS_CHK_S:  begin c.br = BR_JUMP; c.cond = C_SAME; c.target = U_EMIT_NONE; end
            U_BIS_INIT:   begin c.lop = L_INIT_LOOP; end
            U_LOOP:       begin c.lop = L_LD_WIDTH; end
            U_LOOP_TEST:  begin c.br = BR_JUMP; c.cond = C_DONE; c.target = U_EMIT_CONV; end
            U_LOOP_EVAL:  begin c.br = BR_CALL; c.target = U_EVAL; c.xsel = X_MID; end
            U_LOOP_ZERO:  begin c.br = BR_JUMP; c.cond = C_F_ZERO; c.target = U_EMIT_EXACT; end
            U_LOOP_UPD:
            begin
                c.br = BR_JUMP; c.cond = C_ALWAYS; c.target = U_LOOP; c.lop = L_UPDATE;
            end
            U_SCAN:       begin c.lop = L_CNT_CLR; end
            U_SCAN_TOP:   begin c.br = BR_JUMP; c.cond = C_SCAN_END; c.target = U_EMIT_NONE; end
            U_SCAN_LO:
            begin
                c.br = BR_CALL; c.target = U_EVAL; c.xsel = X_SX; c.lop = L_LOAD_WIN;
            end
            U_SCAN_HI:
            begin
                c.br = BR_CALL; c.target = U_EVAL; c.xsel = X_HI; c.lop = L_SAVE_A;
            end
            U_SCAN_CHK:   begin c.br = BR_JUMP; c.cond = C_BRACKET; c.target = U_BIS_CHK_A; end
            U_SCAN_ADV:
            begin
                c.br = BR_JUMP; c.cond = C_ALWAYS; c.target = U_SCAN_TOP; c.lop = L_SCAN_ADV;
            end
            U_EMIT_LO:
            begin
                c.br = BR_JUMP; c.cond = C_ALWAYS; c.target = U_IDLE;
                c.emit = 1'b1; c.rsel = R_LO; c.status = ST_EXACT;
            end
            U_EMIT_HI:
            begin
                c.br = BR_JUMP; c.cond = C_ALWAYS; c.target = U_IDLE;
                c.emit = 1'b1; c.rsel = R_HI; c.status = ST_EXACT;
            end
            U_EMIT_NONE:
            begin
                c.br = BR_JUMP; c.cond = C_ALWAYS; c.target = U_IDLE;
                c.emit = 1'b1; c.rsel = R_ZERO; c.status = ST_NONE;
            end
            U_EMIT_EXACT:
            begin
                c.br = BR_JUMP; c.cond = C_ALWAYS; c.target = U_IDLE;
                c.emit = 1'b1; c.rsel = R_MID; c.status = ST_EXACT;
            end
            U_EMIT_CONV:
            begin
                c.br = BR_JUMP; c.cond = C_ALWAYS; c.target = U_IDLE;
                c.emit = 1'b1; c.rsel = R_MID; c.status = ST_CONV;
            end
            U_EVAL:       begin c.mop = M_QX; c.aop = A_CONST; end
            U_EVAL_1:     begin c.mop = M_LX; c.save_t = 1'b1; end
            U_EVAL_2:     begin c.mop = M_TLO; c.aop = A_ADD_FRAC; end
            U_EVAL_3:     begin c.mop = M_THI; c.aop = A_ADD_LOW; end
            U_EVAL_4:     begin c.aop = A_ADD_HIGH; end
            U_EVAL_5:     begin c.sign_ld = 1'b1; c.br = BR_RET; end
            default:      begin c.br = BR_JUMP; c.cond = C_ALWAYS; c.target = U_IDLE; end
        endcase
        return c;
    endfunction

endpackage

// File: rtl/qbr_sequencer.sv
module qbr_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  qbr_pkg::flags_t flags,
    input  logic            out_busy,
    output qbr_pkg::ctrl_t  ctrl,
    output logic            idle
);
    import qbr_pkg::*;

    addr_t pc_reg, pc_next;
    addr_t ret_reg, ret_next;
    addr_t pc_inc;
    logic  cond_true;

    assign ctrl   = ucode(pc_reg);
    assign idle   = (pc_reg == U_IDLE);
    assign pc_inc = ADDR_BITS'(pc_reg + 1'b1);

    always_comb
    begin
        unique case (ctrl.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_NO_START: cond_true = !start;
            C_SCAN_REQ: cond_true = flags.scan_req;
            C_SA_ZERO:  cond_true = flags.sa_zero;
            C_F_ZERO:   cond_true = flags.f_zero;
            C_SAME:     cond_true = flags.same;
            C_DONE:     cond_true = flags.done;
            C_SCAN_END: cond_true = flags.scan_end;
            C_BRACKET:  cond_true = flags.bracket;
            default:    cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next  = pc_inc;
        ret_next = ret_reg;
        if (ctrl.emit && out_busy)
        begin
            pc_next = pc_reg;    // hold until the result slot frees
        end
        else
        begin
            unique case (ctrl.br)
                BR_NEXT: pc_next = pc_inc;
                BR_JUMP: pc_next = cond_true ? ctrl.target : pc_inc;
                BR_CALL:
                begin
                    pc_next  = ctrl.target;
                    ret_next = pc_inc;
                end
                BR_RET:  pc_next = ret_reg;
                default: pc_next = U_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= U_IDLE;
            ret_reg <= U_IDLE;
        end
        else
        begin
            pc_reg  <= pc_next;
            ret_reg <= ret_next;
        end
    end

endmodule

// File: rtl/qbr_datapath.sv
module qbr_datapath #(
    parameter int FRAC_BITS = 20,
    parameter int MAX_ITER  = 63,
    parameter int MAX_SCAN  = 1023
) (
    input  logic            clk,
    input  logic            rst_n,
    input  qbr_pkg::ctrl_t  ctrl,
    input  logic            req_load,
    input  qbr_pkg::req_t   req,
    input  qbr_pkg::coef_t  coef,
    output qbr_pkg::flags_t flags,
    output qbr_pkg::res_t   result
);
    import qbr_pkg::*;

    localparam int ACC_BITS  = 3 * WORD_BITS + 4;
    localparam int MUL_BITS  = 2 * WORD_BITS;
    localparam int SCAN_BITS = $clog2(MAX_SCAN + 1);
    localparam int CNT_BITS  = (SCAN_BITS > ITER_BITS) ? SCAN_BITS : ITER_BITS;

    word_t lo_reg, hi_reg, mid_reg, x_reg, sx_reg, shi_reg;
    logic  type_reg;
    logic  lsign_reg, sa_neg_reg, sa_zero_reg, f_neg_reg, f_zero_reg;
    logic [WORD_BITS-1:0] w_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [MUL_BITS-1:0]  t_reg, mul_reg;
    logic [ACC_BITS-1:0]  acc_reg;

    logic [WORD_BITS:0]     mid_sum, diff_up, diff_dn, nx_wide;
    word_t                  mid_val;
    logic [WORD_BITS-1:0]   width_val;
    logic                   scan_ovf;
    logic signed [WORD_BITS:0]     mul_a, mul_b;
    logic signed [MUL_BITS+1:0]    prod;
    logic [ACC_BITS-1:0]    mul_ext, const_ext;

    // floor((lo+hi)/2) in raw units
    assign mid_sum = {lo_reg[WORD_BITS-1], lo_reg} + {hi_reg[WORD_BITS-1], hi_reg};
    assign mid_val = mid_sum[WORD_BITS:1];

    assign diff_up   = {hi_reg[WORD_BITS-1], hi_reg} - {lo_reg[WORD_BITS-1], lo_reg};
    assign diff_dn   = {lo_reg[WORD_BITS-1], lo_reg} - {hi_reg[WORD_BITS-1], hi_reg};
    assign width_val = (lo_reg <= hi_reg) ? diff_up[WORD_BITS-1:0] : diff_dn[WORD_BITS-1:0];

    // Window top; overflow when the sum leaves the word range
    assign nx_wide  = {sx_reg[WORD_BITS-1], sx_reg}
                    + {{(WORD_BITS+1-STEP_BITS){1'b0}}, coef.scan_step};
    assign scan_ovf = nx_wide[WORD_BITS] != nx_wide[WORD_BITS-1];

    always_comb
    begin
        case (ctrl.mop)
            M_QX:    mul_a = {coef.quad[WORD_BITS-1], coef.quad};
            M_LX:    mul_a = {coef.lin[WORD_BITS-1], coef.lin};
            M_TLO:   mul_a = {1'b0, t_reg[WORD_BITS-1:0]};
            M_THI:   mul_a = {t_reg[MUL_BITS-1], t_reg[MUL_BITS-1:WORD_BITS]};
            default: mul_a = '0;
        endcase
    end

    assign mul_b = {x_reg[WORD_BITS-1], x_reg};
    assign prod  = mul_a * mul_b;

    assign mul_ext   = {{(ACC_BITS-MUL_BITS){mul_reg[MUL_BITS-1]}}, mul_reg};
    assign const_ext = {{(ACC_BITS-WORD_BITS){coef.cnst[WORD_BITS-1]}}, coef.cnst};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg      <= '0;
            hi_reg      <= '0;
            mid_reg     <= '0;
            x_reg       <= '0;
            sx_reg      <= '0;
            shi_reg     <= '0;
            type_reg    <= REQ_BISECT;
            lsign_reg   <= 1'b0;
            sa_neg_reg  <= 1'b0;
            sa_zero_reg <= 1'b0;
            f_neg_reg   <= 1'b0;
            f_zero_reg  <= 1'b0;
            w_reg       <= '0;
            cnt_reg     <= '0;
            t_reg       <= '0;
            mul_reg     <= '0;
            acc_reg     <= '0;
        end
        else
        begin
            if (req_load)
            begin
                lo_reg   <= req.lower_bound;
                hi_reg   <= req.upper_bound;
                sx_reg   <= req.lower_bound;
                shi_reg  <= req.upper_bound;
                type_reg <= req.req_type;
            end

            case (ctrl.xsel)
                X_LO:  x_reg <= lo_reg;
                X_HI:  x_reg <= hi_reg;
                X_MID:
                begin
                    x_reg   <= mid_val;
                    mid_reg <= mid_val;
                end
                X_SX:  x_reg <= sx_reg;
                default: ;
            endcase

            mul_reg <= prod[MUL_BITS-1:0];
            if (ctrl.save_t)
            begin
                t_reg <= mul_reg;
            end

            case (ctrl.aop)
                A_CONST:    acc_reg <= const_ext << (2 * FRAC_BITS);
                A_ADD_FRAC: acc_reg <= acc_reg + (mul_ext << FRAC_BITS);
                A_ADD_LOW:  acc_reg <= acc_reg + mul_ext;
                A_ADD_HIGH: acc_reg <= acc_reg + (mul_ext << WORD_BITS);
                default: ;
            endcase

            if (ctrl.sign_ld)
            begin
                f_neg_reg  <= acc_reg[ACC_BITS-1];
                f_zero_reg <= (acc_reg == '0);
            end

            unique case (ctrl.lop)
                L_NONE: ;
                L_SAVE_A:
                begin
                    sa_neg_reg  <= f_neg_reg;
                    sa_zero_reg <= f_zero_reg;
                end
                L_INIT_LOOP:
                begin
                    lsign_reg <= sa_neg_reg;
                    cnt_reg   <= '0;
                    mid_reg   <= mid_val;
                end
                L_LD_WIDTH: w_reg <= width_val;
                L_UPDATE:
                begin
                    if (f_neg_reg != lsign_reg)
                    begin
                        hi_reg <= mid_reg;
                    end
                    else
                    begin
                        lo_reg <= mid_reg;
                    end
                    cnt_reg <= CNT_BITS'(cnt_reg + 1'b1);
                end
                L_CNT_CLR: cnt_reg <= '0;
                L_LOAD_WIN:
                begin
                    lo_reg <= sx_reg;
                    hi_reg <= nx_wide[WORD_BITS-1:0];
                end
                L_SCAN_ADV:
                begin
                    sx_reg  <= nx_wide[WORD_BITS-1:0];
                    cnt_reg <= CNT_BITS'(cnt_reg + 1'b1);
                end
            endcase
        end
    end

    assign flags.scan_req = (type_reg == REQ_SCAN);
    assign flags.sa_zero  = sa_zero_reg;
    assign flags.f_zero   = f_zero_reg;
    assign flags.same     = (sa_neg_reg == f_neg_reg);
    assign flags.done     = (w_reg < {{(WORD_BITS-TOL_BITS){1'b0}}, coef.tol})
                         || (cnt_reg >= CNT_BITS'(MAX_ITER));
    assign flags.scan_end = (sx_reg > shi_reg) || (cnt_reg >= CNT_BITS'(MAX_SCAN)) || scan_ovf;
    assign flags.bracket  = sa_zero_reg || f_zero_reg || (sa_neg_reg != f_neg_reg);

    always_comb
    begin
        case (ctrl.rsel)
            R_LO:    result.root = lo_reg;
            R_HI:    result.root = hi_reg;
            R_MID:   result.root = mid_reg;
            default: result.root = '0;
        endcase
        result.status     = ctrl.status;
        result.iterations = (ctrl.rsel == R_MID) ? cnt_reg[ITER_BITS-1:0] : '0;
    end

endmodule

// File: rtl/quadratic_bisection_root_finder.sv
// Quadratic root finder: bisects q*x*x + l*x + c over a signed Q12.20 interval.
// Requests arrive on in_valid/in_ready with in_data (mode, lower and upper bound);
// one result per request leaves on out_valid/out_ready as out_data (root,
// status, iteration count). Coefficients, tolerance and scan step are written on
// cfg_wr_en/cfg_index/cfg_data while the block is idle; unknown indexes are dropped.
// One request is in flight at a time. f(x) is evaluated exactly on one shared
// 33x33 multiplier in six microcode steps, so that unit paces everything:
//   direct bisection : two end evaluations, then one per halving for n halvings (n <= MAX_ITER)
//   bracket scan     : two evaluations per window tested, then the bisection
// A one-deep output register holds the finished transaction; the next request
// is taken as soon as the sequencer is back at its idle step, even while that
// result still waits. If the receiver stalls with the register full, the
// sequencer holds at its emit step. Reset returns the sequencer to idle, clears
// the working registers and the output slot, and restores the default
// coefficients (4, 3, -3), tolerance 1 and scan step 104858.
`include "quadratic_bisection_root_finder_macros.svh"

module quadratic_bisection_root_finder #(
    parameter int FRAC_BITS = 20,
    parameter int MAX_ITER  = 63,
    parameter int MAX_SCAN  = 1023
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  qbr_pkg::req_t                          in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output qbr_pkg::res_t                          out_data,
    input  logic                                   cfg_wr_en,
    input  logic [qbr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [qbr_pkg::WORD_BITS-1:0]          cfg_data
);
    import qbr_pkg::*;

    coef_t  coef_reg;
    ctrl_t  ctrl;
    flags_t flags;
    res_t   result;
    res_t   out_reg;
    logic   out_valid_reg;
    logic   idle;
    logic   req_load;
    logic   out_busy;
    logic   out_load;

    // Configuration writes: take effect on the next edge, no handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.quad      <= COEF_QUAD_RESET;
            coef_reg.lin       <= COEF_LIN_RESET;
            coef_reg.cnst      <= COEF_CONST_RESET;
            coef_reg.tol       <= TOLERANCE_RESET;
            coef_reg.scan_step <= SCAN_STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_COEF_QUAD:  coef_reg.quad      <= cfg_data;
                REG_COEF_LIN:   coef_reg.lin       <= cfg_data;
                REG_COEF_CONST: coef_reg.cnst      <= cfg_data;
                REG_TOLERANCE:  coef_reg.tol       <= cfg_data[TOL_BITS-1:0];
                REG_SCAN_STEP:  coef_reg.scan_step <= cfg_data[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Accept a request only at the idle step of the program
    assign in_ready = idle;
    assign req_load = in_valid && in_ready;

    // The emit step stalls while a previous transaction still waits
    assign out_busy = out_valid_reg && !out_ready;
    assign out_load = ctrl.emit && !out_busy;

    qbr_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_valid),
        .flags    (flags),
        .out_busy (out_busy),
        .ctrl     (ctrl),
        .idle     (idle)
    );

    qbr_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_ITER  (MAX_ITER),
        .MAX_SCAN  (MAX_SCAN)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .req_load (req_load),
        .req      (in_data),
        .coef     (coef_reg),
        .flags    (flags),
        .result   (result)
    );

    // Output slot: load on emit, drop once the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A request is never followed by another in the very next cycle
    `QBR_ASSERT_NEXT(a_no_back_to_back_req, clk, rst_n, req_load, !in_ready)
    // A result is only written into a free or draining slot
    `QBR_ASSERT_NOW(a_load_into_free_slot, clk, rst_n, out_load,
                    !out_valid_reg || out_ready)
    // No bracket means a zero root and no halvings
    `QBR_ASSERT_NOW(a_none_is_empty, clk, rst_n, out_load && (result.status == ST_NONE),
                    (result.root == '0) && (result.iterations == '0))
    // Emission never coincides with accepting a new request
    `QBR_ASSERT_NOW(a_emit_not_idle, clk, rst_n, ctrl.emit, !in_ready)

endmodule

// File: verif/quadratic_bisection_root_finder_test.sv
module quadratic_bisection_root_finder_test;

    import qbr_pkg::*;

    // Tracks every request in flight and the root, status and step count it should produce.
    class root_tracker;
        localparam int     FRAC     = 20;
        localparam int     ITER_CAP = 63;
        localparam int     SCAN_CAP = 1023;
        localparam longint WORD_MAX = 64'sd2147483647;

        word_t                quad;
        word_t                lin;
        word_t                cnst;
        logic [TOL_BITS-1:0]  tol;
        logic [STEP_BITS-1:0] scan_step;

        // working interval of the current bisection
        longint lo_end;
        longint hi_end;
        bit     lo_neg;
        int     halvings;

        res_t expected_roots[$];
        int   errors;

        function new();
            quad      = COEF_QUAD_RESET;
            lin       = COEF_LIN_RESET;
            cnst      = COEF_CONST_RESET;
            tol       = TOLERANCE_RESET;
            scan_step = SCAN_STEP_RESET;
            lo_end    = 0;
            hi_end    = 0;
            lo_neg    = 1'b0;
            halvings  = 0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [WORD_BITS-1:0] data);
            case (idx)
                REG_COEF_QUAD:  quad = data;
                REG_COEF_LIN:   lin = data;
                REG_COEF_CONST: cnst = data;
                REG_TOLERANCE:  tol = data[TOL_BITS-1:0];
                REG_SCAN_STEP:  scan_step = data[STEP_BITS-1:0];
                default:        ;
            endcase
        endfunction

        // Sign of the polynomial, formed exactly in units of 2^-60
        function int sign_at(longint x);
            logic signed [127:0] xw;
            logic signed [127:0] qw;
            logic signed [127:0] lw;
            logic signed [127:0] cw;
            logic signed [127:0] acc;
            xw  = x;
            qw  = quad;
            lw  = lin;
            cw  = cnst;
            acc = (qw * xw * xw) + ((lw * xw) <<< FRAC) + (cw <<< (2 * FRAC));
            if (acc < 0)
                return -1;
            return (acc == 0) ? 0 : 1;
        endfunction

        function res_t make_result(longint root, logic [STATUS_BITS-1:0] st, int steps);
            res_t r;
            r.root       = root[WORD_BITS-1:0];
            r.status     = st;
            r.iterations = steps[ITER_BITS-1:0];
            return r;
        endfunction

        function longint span(longint a, longint b);
            return (a <= b) ? b - a : a - b;
        endfunction

        function res_t bisect_interval(longint a, longint b);
            int     sa;
            int     sb;
            int     sm;
            longint mid;
            sa = sign_at(a);
            sb = sign_at(b);
            if (sa == 0)
                return make_result(a, ST_EXACT, 0);
            if (sb == 0)
                return make_result(b, ST_EXACT, 0);
            if (sa == sb)
                return make_result(0, ST_NONE, 0);
            lo_end   = a;
            hi_end   = b;
            lo_neg   = (sa < 0);
            halvings = 0;
            mid      = (a + b) >>> 1;
            while (span(lo_end, hi_end) >= longint'(tol) && halvings < ITER_CAP)
            begin
                mid = (lo_end + hi_end) >>> 1;
                sm  = sign_at(mid);
                if (sm == 0)
                    return make_result(mid, ST_EXACT, halvings);
                if ((sm < 0) != lo_neg)
                    hi_end = mid;
                else
                    lo_end = mid;
                halvings++;
            end
            return make_result(mid, ST_CONV, halvings);
        endfunction

        function void note_request(req_t req);
            longint lo;
            longint hi;
            longint x;
            longint nx;
            longint stepv;
            int     windows;
            int     sx;
            int     sn;
            bit     found;
            lo = req.lower_bound;
            hi = req.upper_bound;
            if (req.req_type == REQ_BISECT)
            begin
                expected_roots.push_back(bisect_interval(lo, hi));
                return;
            end
            // walk upward window by window until the ends differ in sign or touch zero
            x       = lo;
            nx      = lo;
            stepv   = longint'(scan_step);
            windows = 0;
            found   = 1'b0;
            while (!found && x <= hi && windows < SCAN_CAP && x <= WORD_MAX - stepv)
            begin
                nx = x + stepv;
                sx = sign_at(x);
                sn = sign_at(nx);
                if (sx == 0 || sn == 0 || sx != sn)
                    found = 1'b1;
                else
                begin
                    x = nx;
                    windows++;
                end
            end
            if (found)
                expected_roots.push_back(bisect_interval(x, nx));
            else
                expected_roots.push_back(make_result(0, ST_NONE, 0));
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_roots.size() == 0)
            begin
                $display("%0t: no result expected, got root %0d status %0d iterations %0d",
                         $time, got.root, got.status, got.iterations);
                errors++;
                return;
            end
            want = expected_roots.pop_front();
            if (got.root !== want.root)
            begin
                $display("%0t: root expected %0d, got %0d", $time, want.root, got.root);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.iterations !== want.iterations)
            begin
                $display("%0t: iterations expected %0d, got %0d", $time, want.iterations,
                         got.iterations);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_roots.size();
        endfunction
    endclass

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 8;
    // one result per request, so once nothing is outstanding the sequencer is idle;
    // a short tail covers the return to its idle step
    localparam int SETTLE_CYCLES  = 32;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 64;
    localparam int PRESSURE_ITEMS = 10;
    // watchdog limit for the slowest run of this stimulus
    localparam int LIMIT_CYCLES   = 7500000;

    localparam word_t ONE      = 32'sh0010_0000;
    localparam word_t WORD_MIN = 32'sh8000_0000;
    localparam word_t WORD_TOP = 32'sh7FFF_FFFF;
    localparam logic [TOL_BITS-1:0]  TOL_MAX  = '1;
    localparam logic [STEP_BITS-1:0] STEP_MAX = '1;

    typedef enum int {SET_DEFAULT, SET_SMALL, SET_WILD, SET_LINEAR, SET_SQUARE} setting_t;
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    req_t                      in_data;
    logic                      out_valid;
    logic                      out_ready;
    res_t                      out_data;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [WORD_BITS-1:0]      cfg_data;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // bumped by the stimulus to ask the result side for one long hold-off
    int holdoff_req    = 0;

    root_tracker tracker;

    quadratic_bisection_root_finder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic req_t make_req(logic kind, longint lo, longint hi);
        req_t r;
        r.req_type    = kind;
        r.lower_bound = lo[WORD_BITS-1:0];
        r.upper_bound = hi[WORD_BITS-1:0];
        return r;
    endfunction

    // Random value clustered near zero, magnitude spread over many octaves
    function automatic longint near_zero();
        return longint'($signed($urandom)) >>> $urandom_range(0, 28);
    endfunction

    task automatic set_idling(idling_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 86; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default:       begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
    endtask

    // Offer one request and hold it until the block takes the transaction
    task automatic send_request(req_t req);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_request(req);
    endtask

    // Drop valid and wait until every outstanding result has been taken
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Keep write enable high across back-to-back writes; the caller lowers it
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [WORD_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    // Write a complete setting while idle; the spare top bit of the narrow registers is
    // driven at random since the block must ignore it
    task automatic load_setting(word_t q, word_t l, word_t c, logic [TOL_BITS-1:0] tol_v,
                                logic [STEP_BITS-1:0] step_v, bit poke_unused);
        settle();
        write_reg(REG_COEF_QUAD, q);
        write_reg(REG_COEF_LIN, l);
        write_reg(REG_COEF_CONST, c);
        write_reg(REG_TOLERANCE, {1'($urandom_range(1)), tol_v});
        write_reg(REG_SCAN_STEP, {1'($urandom_range(1)), step_v});
        if (poke_unused)
        begin
            // indexes past the last register must leave every setting untouched
            for (int idx = int'(REG_SCAN_STEP) + 1; idx < (1 << CFG_INDEX_BITS); idx++)
                write_reg(CFG_INDEX_BITS'(idx), $urandom);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic pick_setting(setting_t kind);
        word_t                q;
        word_t                l;
        word_t                c;
        logic [TOL_BITS-1:0]  tol_v;
        logic [STEP_BITS-1:0] step_v;
        case (kind)
            SET_DEFAULT:
            begin
                q = COEF_QUAD_RESET;
                l = COEF_LIN_RESET;
                c = COEF_CONST_RESET;
            end
            SET_SMALL:
            begin
                q = $signed($urandom) >>> $urandom_range(6, 12);
                l = $signed($urandom) >>> $urandom_range(6, 12);
                c = $signed($urandom) >>> $urandom_range(6, 12);
            end
            SET_WILD:
            begin
                q = $urandom;
                l = $urandom;
                c = $urandom;
            end
            SET_LINEAR:
            begin
                // f = x + c has its root on a raw grid point, so midpoints can hit it
                q = '0;
                l = ONE;
                c = -($signed($urandom) >>> $urandom_range(8, 20));
            end
            default:
            begin
                q = ONE;
                l = '0;
                c = -word_t'($urandom_range(1, 16 * ONE));
            end
        endcase
        case ($urandom_range(3))
            0:       tol_v = '0;
            1:       tol_v = 31'd1;
            2:       tol_v = 31'(1) << $urandom_range(0, 24);
            default: tol_v = 31'($urandom);
        endcase
        case ($urandom_range(2))
            0:       step_v = (31'(1) << $urandom_range(12, 22)) + 31'($urandom_range(0, 999));
            1:       step_v = 31'($urandom_range(1, 100));
            default: step_v = 31'($urandom) | 31'd1;
        endcase
        load_setting(q, l, c, tol_v, step_v, 1'b0);
    endtask

    // Mostly bracketing intervals and short scans; a little noise over the full range
    task automatic random_item();
        longint a;
        longint b;
        longint hi_l;
        int     pick;
        int     k;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            a = near_zero();
            b = near_zero();
            for (int t = 0; t < 8 && tracker.sign_at(a) == tracker.sign_at(b); t++)
            begin
                a = near_zero();
                b = near_zero();
            end
            send_request(make_req(REQ_BISECT, a, b));
        end
        else if (pick < 85)
        begin
            // keep the window count small so that scans stay cheap
            a    = near_zero();
            k    = $urandom_range(0, 40);
            hi_l = a + longint'(k) * longint'(tracker.scan_step);
            if (hi_l > longint'(WORD_TOP))
                hi_l = WORD_TOP;
            send_request(make_req(REQ_SCAN, a, hi_l));
        end
        else if (pick < 99)
        begin
            send_request(make_req(REQ_BISECT, $signed($urandom), $signed($urandom)));
        end
        else
        begin
            send_request(make_req(REQ_SCAN, $signed($urandom), $signed($urandom)));
        end
    endtask

    // Result side: check every transaction, stall at random, and honour hold-off requests
    initial
    begin : result_sink
        int hold_left;
        int holdoff_seen;
        out_ready    = 1'b0;
        hold_left    = 0;
        holdoff_seen = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.check_result(out_data);
            if (holdoff_req != holdoff_seen)
            begin
                holdoff_seen = holdoff_req;
                hold_left    = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("quadratic_bisection_root_finder: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        tracker   = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        set_idling(IDLE_NONE);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default polynomial 4x^2 + 3x - 3 straight out of reset
        send_request(make_req(REQ_BISECT, 0, ONE));
        send_request(make_req(REQ_BISECT, ONE, 0));               // ends in reverse order
        send_request(make_req(REQ_BISECT, 2 * ONE, 3 * ONE));     // same sign at both ends
        send_request(make_req(REQ_BISECT, WORD_MIN, WORD_TOP));
        send_request(make_req(REQ_SCAN, -3 * ONE, 3 * ONE));
        send_request(make_req(REQ_SCAN, 2 * ONE, 3 * ONE));       // no bracket in range
        send_request(make_req(REQ_SCAN, 32'sh7FFF_0000, WORD_TOP)); // window passes the top
        send_request(make_req(REQ_SCAN, ONE, -ONE));              // scan range empty

        // f = x - 1 with zero tolerance: exact hits at ends and midpoints, iteration cap
        load_setting('0, ONE, -ONE, '0, 31'h0004_0000, 1'b1);
        send_request(make_req(REQ_BISECT, ONE, 2 * ONE));         // zero at the lower end
        send_request(make_req(REQ_BISECT, 0, ONE));               // zero at the upper end
        send_request(make_req(REQ_BISECT, 0, 2 * ONE));           // first midpoint is the root
        send_request(make_req(REQ_BISECT, 0, 4 * ONE));           // root after one halving
        send_request(make_req(REQ_BISECT, WORD_MIN, WORD_TOP));
        send_request(make_req(REQ_BISECT, -3 * ONE, ONE + 12345));
        send_request(make_req(REQ_SCAN, 0, 2 * ONE));             // window ends on the root

        // Widest tolerance and unit scan step
        load_setting('0, ONE, -ONE, TOL_MAX, 31'd1, 1'b0);
        send_request(make_req(REQ_BISECT, 0, ONE + ONE / 2));     // already narrow enough
        send_request(make_req(REQ_SCAN, 0, 2000));                // runs out of windows
        send_request(make_req(REQ_SCAN, ONE - 5, ONE + 5));

        // Coefficient extremes and the largest step
        load_setting(WORD_MIN, WORD_TOP, WORD_MIN, 31'd1, STEP_MAX, 1'b0);
        send_request(make_req(REQ_BISECT, WORD_MIN, WORD_TOP));
        send_request(make_req(REQ_BISECT, -1, 1));
        send_request(make_req(REQ_SCAN, WORD_TOP - 10, WORD_TOP));
        send_request(make_req(REQ_SCAN, WORD_MIN, WORD_MIN + 10));

        // Hold the result side off for a long stretch while requests keep coming, so
        // the output slot fills and the block has to stall its input
        load_setting(COEF_QUAD_RESET, COEF_LIN_RESET, COEF_CONST_RESET, TOLERANCE_RESET,
                     SCAN_STEP_RESET, 1'b0);
        set_idling(IDLE_NONE);
        holdoff_req++;
        repeat (PRESSURE_ITEMS) random_item();

        // Random phases: advance through settings and idling patterns
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            pick_setting(setting_t'(p % 5));
            set_idling(idling_t'(p % 4));
            repeat (PHASE_ITEMS) random_item();
        end

        settle();
        if (tracker.errors == 0)
        begin
            $display("quadratic_bisection_root_finder: match");
        end
        else
        begin
            $display("quadratic_bisection_root_finder: mismatch");
        end
        $finish;
    end

endmodule
